[rtl/smes_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// smes_pkg: shared types and codes of the sparse matrix entry store
// Request and result words, stored entry layout, opcodes, status codes,
// configuration register indexes and controller states.
// ----------------------------------------------------------------------------
package smes_pkg;

  // Opcodes of a request word
  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Status codes of a result word
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_ROW_COUNT    = 2'd0;
  localparam logic [1:0] REG_COLUMN_COUNT = 2'd1;

  // Dimension registers after reset
  localparam logic [8:0] DIM_RESET = 9'd256;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [7:0]         row_index;
    logic [7:0]         column_index;
    logic signed [31:0] element_value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic               hit;
    logic [1:0]         status;
  } rsp_t;

  // One slot of the entry memory
  typedef struct packed {
    logic        valid;
    logic [7:0]  row;
    logic [7:0]  column;
    logic [31:0] data;
  } entry_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_ACT
  } state_t;

endpackage
`default_nettype wire

[rtl/sparse_matrix_entry_store_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_matrix_entry_store_top: bounded coordinate-list store of matrix entries
// An out-of-range index or an unused opcode skips the scan; other requests scan the
//   slots one per cycle and stop early on a match.
// Throughput: one request at a time; busy drops as the result is strobed on done.
// Reset: a clearing pass invalidates every slot under busy;
//   results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module sparse_matrix_entry_store_top #(
  parameter int CAPACITY    = 64,
  parameter int INDEX_LIMIT = 256
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire smes_pkg::req_t request,
  output logic               done,
  output smes_pkg::rsp_t     result,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [8:0]    cfg_data
);
  import smes_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);

  // Entry memory: one write port, one registered read port
  entry_t        mem [CAPACITY];
  entry_t        rdata;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;

  // Controller and request registers
  state_t        state, state_next;
  req_t          req;
  logic          skip;
  logic [8:0]    row_count, column_count;
  logic [AW-1:0] issue_addr;
  logic          issue_en;
  logic [AW-1:0] cmp_addr;
  logic          cmp_vld;
  logic          hit;
  logic [AW-1:0] hit_idx;
  logic [31:0]   hit_data;
  logic          free_found;
  logic [AW-1:0] free_idx;
  logic          coord_outside;
  logic          slot_match;
  rsp_t          rsp_next;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  // Check the incoming coordinate against the dimensions
  assign coord_outside = ({1'b0, request.row_index} >= row_count) ||
                         ({1'b0, request.column_index} >= column_count) ||
                         ({24'd0, request.row_index} >= 32'(INDEX_LIMIT)) ||
                         ({24'd0, request.column_index} >= 32'(INDEX_LIMIT));

  assign slot_match = cmp_vld && rdata.valid && (rdata.row == req.row_index) &&
                      (rdata.column == req.column_index);

  // Hold the entry memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[issue_addr];
  end

  // Write the dimension registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= DIM_RESET;
      column_count <= DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROW_COUNT:    row_count    <= cfg_data;
        REG_COLUMN_COUNT: column_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state, memory writes and the result word
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = issue_addr;
    mem_wdata  = '0;
    rsp_next   = '0;
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (issue_addr == LAST_SLOT) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (coord_outside || request.opcode == OP_UNUSED) begin
            state_next = ST_ACT;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (slot_match || (cmp_vld && cmp_addr == LAST_SLOT)) begin
          state_next = ST_ACT;
        end
      end
      ST_ACT: begin
        state_next = ST_IDLE;
        if (skip) begin
          if (req.opcode != OP_UNUSED) begin
            rsp_next.status = STATUS_RANGE;
          end
        end else begin
          rsp_next.hit = hit;
          case (req.opcode)
            OP_READ: begin
              if (hit) begin
                rsp_next.read_value = hit_data;
              end
            end
            OP_WRITE: begin
              mem_wdata = '{valid: 1'b1, row: req.row_index,
                            column: req.column_index, data: req.element_value};
              if (hit) begin
                mem_we    = 1'b1;
                mem_waddr = hit_idx;
              end else if (free_found) begin
                mem_we    = 1'b1;
                mem_waddr = free_idx;
              end else begin
                rsp_next.status = STATUS_FULL;
              end
            end
            OP_DELETE: begin
              if (hit) begin
                mem_we    = 1'b1;
                mem_waddr = hit_idx;
              end
            end
            default: ;
          endcase
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Scan datapath: issue one slot a cycle, compare it in the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_addr <= '0;
      issue_en   <= 1'b0;
      cmp_vld    <= 1'b0;
      done       <= 1'b0;
    end else begin
      done    <= (state == ST_ACT);
      cmp_vld <= 1'b0;
      case (state)
        ST_CLEAR: begin
          if (issue_addr == LAST_SLOT) begin
            issue_addr <= '0;
          end else begin
            issue_addr <= issue_addr + 1'b1;
          end
        end
        ST_IDLE: begin
          issue_addr <= '0;
          issue_en   <= 1'b0;
          if (start) begin
            issue_en <= ~(coord_outside || request.opcode == OP_UNUSED);
          end
        end
        ST_SCAN: begin
          cmp_vld  <= issue_en && !slot_match;
          cmp_addr <= issue_addr;
          if (slot_match) begin
            issue_en <= 1'b0;
          end else if (issue_en) begin
            if (issue_addr == LAST_SLOT) begin
              issue_en <= 1'b0;
            end else begin
              issue_addr <= issue_addr + 1'b1;
            end
          end
        end
        default: begin
          issue_en <= 1'b0;
        end
      endcase
    end
  end

  // Latch the request and collect the scan outcome
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      req        <= request;
      skip       <= coord_outside || request.opcode == OP_UNUSED;
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else if (state == ST_SCAN && cmp_vld) begin
      if (slot_match) begin
        hit      <= 1'b1;
        hit_idx  <= cmp_addr;
        hit_data <= rdata.data;
      end
      if (!rdata.valid && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= cmp_addr;
      end
    end
  end

  // Register the result word
  always_ff @(posedge clk) begin
    if (state == ST_ACT) begin
      result <= rsp_next;
    end
  end

endmodule
`default_nettype wire

[tb/sv/smes_checker.sv]
// ----------------------------------------------------------------------------
// smes_checker: result checker for the sparse matrix entry store
// Watches the request, result and register channels, keeps its own copy of
// the entry table and dimensions, forecasts the answer to every accepted
// request and compares each strobed result word with the oldest forecast.
// ----------------------------------------------------------------------------
module smes_checker #(
  parameter int CAPACITY    = 64,
  parameter int INDEX_LIMIT = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           busy,
  input  smes_pkg::req_t request,
  input  logic           done,
  input  smes_pkg::rsp_t result,
  input  logic           cfg_valid,
  input  logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [8:0]     cfg_data,
  output int             fail_count,
  output int             pending,
  output int             answered,
  output int             hits,
  output int             fulls,
  output int             ranges
);
  import smes_pkg::*;

  // Shadow copy of the dimension registers and the entry table
  logic [8:0]  rows_in_use;
  logic [8:0]  cols_in_use;
  logic        slot_used [CAPACITY];
  logic [7:0]  slot_row  [CAPACITY];
  logic [7:0]  slot_col  [CAPACITY];
  logic [31:0] slot_data [CAPACITY];

  rsp_t expected_answers [$];

  int faults;
  int n_answered;
  int n_hits;
  int n_fulls;
  int n_ranges;

  initial begin
    faults     = 0;
    n_answered = 0;
    n_hits     = 0;
    n_fulls    = 0;
    n_ranges   = 0;
  end

  // Work out the answer to one request and update the shadow table
  function automatic rsp_t resolve_request(input req_t rq);
    rsp_t ans;
    int   match;
    int   spare;
    ans   = '0;
    match = -1;
    spare = -1;
    if (rq.opcode == OP_READ || rq.opcode == OP_WRITE || rq.opcode == OP_DELETE) begin
      if ({1'b0, rq.row_index} >= rows_in_use || {1'b0, rq.column_index} >= cols_in_use ||
          int'(rq.row_index) >= INDEX_LIMIT || int'(rq.column_index) >= INDEX_LIMIT) begin
        ans.status = STATUS_RANGE;
      end else begin
        for (int k = 0; k < CAPACITY; k++) begin
          if (match < 0 && slot_used[k] && slot_row[k] == rq.row_index &&
              slot_col[k] == rq.column_index)
            match = k;
          if (spare < 0 && !slot_used[k])
            spare = k;
        end
        ans.hit = (match >= 0);
        if (rq.opcode == OP_READ) begin
          if (match >= 0)
            ans.read_value = slot_data[match];
        end else if (rq.opcode == OP_WRITE) begin
          if (match >= 0) begin
            slot_data[match] = rq.element_value;
          end else if (spare >= 0) begin
            slot_used[spare] = 1'b1;
            slot_row[spare]  = rq.row_index;
            slot_col[spare]  = rq.column_index;
            slot_data[spare] = rq.element_value;
          end else begin
            ans.status = STATUS_FULL;
          end
        end else if (match >= 0) begin
          slot_used[match] = 1'b0;
        end
      end
    end
    return ans;
  endfunction

  // Compare results, track register writes, queue forecasts
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      rows_in_use = DIM_RESET;
      cols_in_use = DIM_RESET;
      for (int k = 0; k < CAPACITY; k++)
        slot_used[k] = 1'b0;
      expected_answers.delete();
    end else begin
      // check the result word against the oldest forecast
      if (done) begin
        if (expected_answers.size() == 0) begin
          faults++;
          $display("%0t smes_checker: result word with nothing expected, actual %0d/%0d/%0d",
                   $time, result.read_value, result.hit, result.status);
        end else begin
          want = expected_answers.pop_front();
          n_answered++;
          if (want.hit)
            n_hits++;
          if (want.status == STATUS_FULL)
            n_fulls++;
          if (want.status == STATUS_RANGE)
            n_ranges++;
          if (result.read_value !== want.read_value) begin
            faults++;
            $display("%0t smes_checker: read_value mismatch, expected %0d, actual %0d",
                     $time, want.read_value, result.read_value);
          end
          if (result.hit !== want.hit) begin
            faults++;
            $display("%0t smes_checker: hit mismatch, expected %0d, actual %0d",
                     $time, want.hit, result.hit);
          end
          if (result.status !== want.status) begin
            faults++;
            $display("%0t smes_checker: status mismatch, expected %0d, actual %0d",
                     $time, want.status, result.status);
          end
        end
      end
      // follow the dimension registers
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_ROW_COUNT)
          rows_in_use = cfg_data;
        else if (cfg_index == REG_COLUMN_COUNT)
          cols_in_use = cfg_data;
      end
      // forecast the answer to an accepted request word
      if (start && !busy)
        expected_answers.push_back(resolve_request(request));
    end
    fail_count <= faults;
    pending    <= expected_answers.size();
    answered   <= n_answered;
    hits       <= n_hits;
    fulls      <= n_fulls;
    ranges     <= n_ranges;
  end

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench of the sparse matrix entry store
// Drives a directed run over the field extremes, every opcode and the range,
// overwrite and delete cases, then random request streams that also fill the table
// under several row and column dimensions with varying sender idling. Checking is
// done by smes_checker beside the block; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import smes_pkg::*;

  localparam int         CAPACITY    = 64;
  localparam int         INDEX_LIMIT = 256;
  localparam logic [1:0] REG_SPARE   = 2'd3;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       start     = 1'b0;
  req_t       request   = '0;
  logic       cfg_valid = 1'b0;
  logic [1:0] cfg_index = REG_ROW_COUNT;
  logic [8:0] cfg_data  = '0;
  logic       busy;
  logic       done;
  rsp_t       result;
  logic       cfg_ready;

  int fail_count;
  int pending;
  int answered;
  int hits;
  int fulls;
  int ranges;
  int send_idle_pct = 16;
  int dim_settings  = 0;

  sparse_matrix_entry_store_top #(
    .CAPACITY    (CAPACITY),
    .INDEX_LIMIT (INDEX_LIMIT)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  smes_checker #(
    .CAPACITY    (CAPACITY),
    .INDEX_LIMIT (INDEX_LIMIT)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .request    (request),
    .done       (done),
    .result     (result),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .answered   (answered),
    .hits       (hits),
    .fulls      (fulls),
    .ranges     (ranges)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one request word until taken, idling the sender at random
  task automatic issue(input req_t rq);
    logic taken;
    taken = 1'b0;
    request <= rq;
    while (!taken) begin
      if ($urandom_range(99) < send_idle_pct)
        start <= 1'b0;
      else
        start <= 1'b1;
      @(posedge clk);
      taken = start && !busy;
    end
  endtask

  task automatic issue_op(input logic [1:0] op, input logic [7:0] r, input logic [7:0] c,
                          input logic [31:0] v);
    req_t rq;
    rq.opcode        = op;
    rq.row_index     = r;
    rq.column_index  = c;
    rq.element_value = v;
    issue(rq);
  endtask

  // Hold a register word on the channel until it is taken; valid stays high
  task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
  endtask

  // Drop start and wait until every forecast has been answered
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_dims(input logic [8:0] rows, input logic [8:0] cols,
                          input logic with_spare);
    settle();
    write_reg(REG_ROW_COUNT, rows);
    write_reg(REG_COLUMN_COUNT, cols);
    if (with_spare)
      write_reg(REG_SPARE, 9'h1FF);
    cfg_valid <= 1'b0;
    dim_settings++;
  endtask

  // Mostly in-range coordinates inside a small window so hits and a full
  // table are common; the rest spread over the whole index space
  function automatic req_t random_request(input logic [8:0] rows, input logic [8:0] cols);
    req_t rq;
    int   pick;
    int   hot_rows;
    int   hot_cols;
    hot_rows = (rows == 0 || rows > 256) ? 256 : int'(rows);
    hot_cols = (cols == 0 || cols > 256) ? 256 : int'(cols);
    pick = $urandom_range(99);
    if (pick < 45)
      rq.opcode = OP_WRITE;
    else if (pick < 72)
      rq.opcode = OP_READ;
    else if (pick < 95)
      rq.opcode = OP_DELETE;
    else
      rq.opcode = OP_UNUSED;
    if ($urandom_range(9) == 0) begin
      rq.row_index    = 8'($urandom_range(255));
      rq.column_index = 8'($urandom_range(255));
    end else begin
      rq.row_index    = 8'($urandom_range(hot_rows - 1));
      rq.column_index = 8'($urandom_range(hot_cols - 1));
    end
    case ($urandom_range(15))
      0:       rq.element_value = 32'h7FFF_FFFF;
      1:       rq.element_value = 32'h8000_0000;
      2:       rq.element_value = '0;
      3:       rq.element_value = '1;
      default: rq.element_value = $urandom;
    endcase
    return rq;
  endfunction

  task automatic run_phase(input logic [8:0] rows, input logic [8:0] cols, input int items,
                           input int idle_pct);
    set_dims(rows, cols, 1'b0);
    send_idle_pct = idle_pct;
    for (int n = 0; n < items; n++)
      issue(random_request(rows, cols));
  endtask

  initial begin
    int waited;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset dimensions
    issue_op(OP_READ,   8'd0,   8'd0,   32'd0);
    issue_op(OP_WRITE,  8'd0,   8'd0,   32'h7FFF_FFFF);
    issue_op(OP_READ,   8'd0,   8'd0,   32'd0);
    issue_op(OP_WRITE,  8'd0,   8'd0,   32'h8000_0000);
    issue_op(OP_READ,   8'd0,   8'd0,   32'hFFFF_FFFF);
    issue_op(OP_WRITE,  8'd255, 8'd255, 32'hFFFF_FFFF);
    issue_op(OP_WRITE,  8'd255, 8'd0,   32'h5555_5555);
    issue_op(OP_WRITE,  8'd0,   8'd255, 32'hAAAA_AAAA);
    issue_op(OP_READ,   8'd255, 8'd255, 32'd0);
    issue_op(OP_READ,   8'd255, 8'd0,   32'd0);
    issue_op(OP_READ,   8'd0,   8'd255, 32'd0);
    issue_op(OP_DELETE, 8'd255, 8'd255, 32'd0);
    issue_op(OP_DELETE, 8'd255, 8'd255, 32'd0);
    issue_op(OP_READ,   8'd255, 8'd255, 32'd0);
    issue_op(OP_UNUSED, 8'd0,   8'd0,   32'h1234_5678);
    issue_op(OP_DELETE, 8'd0,   8'd0,   32'd0);

    // One row only: every other row is out of range, for reads, writes and deletes
    set_dims(9'd1, 9'd256, 1'b0);
    issue_op(OP_WRITE,  8'd0, 8'd200, 32'd77);
    issue_op(OP_READ,   8'd1, 8'd0,   32'd0);
    issue_op(OP_DELETE, 8'd1, 8'd0,   32'd0);
    issue_op(OP_WRITE,  8'd1, 8'd5,   32'd9);

    // Zero rows: nothing is in range
    set_dims(9'd0, 9'd256, 1'b1);
    issue_op(OP_READ,   8'd0,   8'd0, 32'd0);
    issue_op(OP_DELETE, 8'd255, 8'd0, 32'd0);

    // Counts above the index space admit every index
    set_dims(9'd511, 9'd511, 1'b0);
    issue_op(OP_READ,  8'd255, 8'd0,   32'd0);
    issue_op(OP_WRITE, 8'd255, 8'd255, 32'd0);

    // Random streams: sender idles 16, then 66, then 0 percent
    run_phase(9'd12,  9'd12,  180, 16);
    run_phase(9'd6,   9'd6,   120, 66);
    run_phase(9'd3,   9'd200, 80,  66);
    run_phase(9'd16,  9'd9,   90,  0);
    run_phase(9'd511, 9'd511, 30,  0);

    // Drain the last answers, then allow for a stray late word
    start <= 1'b0;
    @(posedge clk);
    waited = 0;
    while ((pending != 0 || busy) && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (CAPACITY + 8) @(posedge clk);

    $display("tb_top: %0d requests answered: %0d hits, %0d table-full, %0d out-of-range",
             answered, hits, fulls, ranges);
    $display("tb_top: %0d dimension settings, sender idling at 16, 66 and 0 percent",
             dim_settings);
    if (fail_count == 0 && pending == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
